// ===== rtl/sat_pkg.sv =====
// shared types and constants for the section address translator
// used by sat_cell and section_address_translator; no dependencies
`default_nettype none

package sat_pkg;

    // number of region cells in the chain
    localparam int REGION_SLOTS = 64;

    // fixed field widths
    localparam int ADDR_W = 64;
    localparam int SLOT_W = 6;
    localparam int IDX_W  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    // width used to compare a load slot against a cell index
    localparam int CMP_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    // stream widths
    localparam int IN_DATA_W  = 328;
    localparam int OUT_DATA_W = 72;

    // item kinds carried in tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    // result codes
    typedef enum logic [1:0] {
        ST_LOADED   = 2'd0,
        ST_HIT      = 2'd1,
        ST_MISS     = 2'd2,
        ST_UNBACKED = 2'd3
    } status_t;

    // one item as it moves down the cell chain
    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_size;
        logic [ADDR_W-1:0] backed_size;
        logic [ADDR_W-1:0] target_offset;
        logic [ADDR_W-1:0] query_address;
        logic              found;
        logic              unbacked;
        logic [SLOT_W-1:0] hit_slot;
        logic [ADDR_W-1:0] hit_delta;
        logic [ADDR_W-1:0] hit_offset;
    } beat_t;

endpackage

`default_nettype wire

// ===== rtl/section_address_translator.sv =====
// top level of the section address translator: stream ports, cell chain, result stage
// depends on sat_pkg and sat_cell
`default_nettype none

// Translates addresses through a table of REGION_SLOTS regions, one region per cell
// in a chain. Load beats (tuser 0) and translate beats (tuser 1) enter in order and
// walk the chain together, so a translate always sees every load accepted before it.
// The block accepts one beat per clock cycle while the result side keeps up; each
// beat passes two registers in every cell (distance, then size and backed compares)
// and then the result register, from which its result is presented on the master side.
// A stall on the result side holds the whole chain.
// After reset every slot is unmapped and a translate returns "no region".

module section_address_translator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // slave side
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // tdata: slot, region_base, region_size, backed_size, target_offset,
    //        query_address, zero pad
    input  wire logic [sat_pkg::IN_DATA_W-1:0] s_tdata,
    // tuser: opcode
    input  wire logic                          s_tuser,
    // master side
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // tdata: translated_offset, hit_slot, zero pad
    output logic [sat_pkg::OUT_DATA_W-1:0]     m_tdata,
    // tuser: status
    output logic [1:0]                         m_tuser
);

    logic           advance;
    logic           chain_valid [0:sat_pkg::REGION_SLOTS];
    sat_pkg::beat_t chain_item  [0:sat_pkg::REGION_SLOTS];
    sat_pkg::beat_t last_item;

    logic                        out_valid_reg;
    sat_pkg::status_t            status_reg;
    sat_pkg::status_t            status_next;
    logic [sat_pkg::ADDR_W-1:0]  xoffset_reg;
    logic [sat_pkg::ADDR_W-1:0]  xoffset_next;
    logic [sat_pkg::SLOT_W-1:0]  hit_slot_reg;
    logic [sat_pkg::SLOT_W-1:0]  hit_slot_next;

    // chain moves whenever the result register is free or being emptied
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    // unpack the incoming beat
    always_comb
    begin
        chain_item[0]               = '0;
        chain_item[0].opcode        = s_tuser;
        chain_item[0].slot          = s_tdata[5:0];
        chain_item[0].region_base   = s_tdata[69:6];
        chain_item[0].region_size   = s_tdata[133:70];
        chain_item[0].backed_size   = s_tdata[197:134];
        chain_item[0].target_offset = s_tdata[261:198];
        chain_item[0].query_address = s_tdata[325:262];
    end
    assign chain_valid[0] = s_tvalid;

    // row of region cells
    for (genvar i = 0; i < sat_pkg::REGION_SLOTS; i++)
    begin : g_cell
        sat_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .cell_index (sat_pkg::CMP_W'(i)),
            .in_valid   (chain_valid[i]),
            .in_item    (chain_item[i]),
            .out_valid  (chain_valid[i+1]),
            .out_item   (chain_item[i+1])
        );
    end

    assign last_item = chain_item[sat_pkg::REGION_SLOTS];

    // result formation
    always_comb
    begin
        status_next   = sat_pkg::ST_LOADED;
        xoffset_next  = '0;
        hit_slot_next = '0;
        if (last_item.opcode == sat_pkg::OP_XLATE)
        begin
            if (!last_item.found)
            begin
                status_next = sat_pkg::ST_MISS;
            end
            else if (last_item.unbacked)
            begin
                status_next   = sat_pkg::ST_UNBACKED;
                hit_slot_next = last_item.hit_slot;
            end
            else
            begin
                status_next   = sat_pkg::ST_HIT;
                hit_slot_next = last_item.hit_slot;
                xoffset_next  = last_item.hit_offset + last_item.hit_delta;
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[sat_pkg::REGION_SLOTS];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg   <= status_next;
            xoffset_reg  <= xoffset_next;
            hit_slot_reg <= hit_slot_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, hit_slot_reg, xoffset_reg};
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire

// ===== rtl/sat_cell.sv =====
// one region cell: holds a single slot and checks passing queries in two stages
// depends on sat_pkg
`default_nettype none

module sat_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     advance,
    input  wire logic [sat_pkg::CMP_W-1:0] cell_index,
    input  wire logic                     in_valid,
    input  wire sat_pkg::beat_t           in_item,
    output logic                          out_valid,
    output sat_pkg::beat_t                out_item
);

    // region held by this cell
    logic [sat_pkg::ADDR_W-1:0] base_reg;
    logic [sat_pkg::ADDR_W-1:0] size_reg;
    logic [sat_pkg::ADDR_W-1:0] backed_reg;
    logic [sat_pkg::ADDR_W-1:0] offset_reg;

    // middle stage
    logic                       mid_valid_reg;
    sat_pkg::beat_t             mid_item_reg;
    logic                       mid_cand_reg;
    logic [sat_pkg::ADDR_W-1:0] mid_delta_reg;
    logic                       mid_cand_next;
    logic [sat_pkg::ADDR_W-1:0] mid_delta_next;

    // last stage
    logic                       out_valid_reg;
    sat_pkg::beat_t             out_item_reg;
    sat_pkg::beat_t             out_item_next;

    logic                       load_hit;
    logic                       borrow;
    logic                       in_range;

    // load beat aimed at this cell
    assign load_hit = in_valid && (in_item.opcode == sat_pkg::OP_LOAD)
                      && ({{(sat_pkg::CMP_W-sat_pkg::SLOT_W){1'b0}}, in_item.slot}
                          == cell_index);

    // first stage: distance from base, address must not lie below it
    always_comb
    begin
        {borrow, mid_delta_next} = {1'b0, in_item.query_address} - {1'b0, base_reg};
        mid_cand_next = in_valid && (in_item.opcode == sat_pkg::OP_XLATE)
                        && !in_item.found && (base_reg != '0) && !borrow;
    end

    // second stage: distance within mapped size
    assign in_range = mid_cand_reg && (mid_delta_reg < size_reg);

    always_comb
    begin
        out_item_next = mid_item_reg;
        if (in_range)
        begin
            out_item_next.found      = 1'b1;
            out_item_next.unbacked   = !(mid_delta_reg < backed_reg);
            out_item_next.hit_slot   = cell_index[sat_pkg::SLOT_W-1:0];
            out_item_next.hit_delta  = mid_delta_reg;
            out_item_next.hit_offset = offset_reg;
        end
    end

    // base starts at zero so the slot reads as unmapped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (advance && load_hit)
        begin
            base_reg <= in_item.region_base;
        end
    end

    // remaining region fields, only read once base is nonzero
    always_ff @(posedge clk)
    begin
        if (advance && load_hit)
        begin
            size_reg   <= in_item.region_size;
            backed_reg <= in_item.backed_size;
            offset_reg <= in_item.target_offset;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mid_valid_reg <= in_valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mid_item_reg  <= in_item;
            mid_cand_reg  <= mid_cand_next;
            mid_delta_reg <= mid_delta_next;
            out_item_reg  <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== verif/section_address_translator_tb.sv =====
// self-checking testbench for section_address_translator
// depends on sat_pkg and the rtl top level; predicts region lookups and checks each result beat
`timescale 1ns / 1ps

module section_address_translator_tb;

    import sat_pkg::*;

    localparam int XLATE_LATENCY = 2 * REGION_SLOTS + 1;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_STRETCH  = 400;

    // one expected result beat
    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] offset;
        logic [SLOT_W-1:0] hit_slot;
    } xlate_result_t;

    // region table mirror and queue of results still owed by the block
    class region_table_mirror;
        logic [ADDR_W-1:0] base_tab   [REGION_SLOTS];
        logic [ADDR_W-1:0] size_tab   [REGION_SLOTS];
        logic [ADDR_W-1:0] backed_tab [REGION_SLOTS];
        logic [ADDR_W-1:0] offset_tab [REGION_SLOTS];
        xlate_result_t     owed_results [$];
        int                errors;

        function new();
            for (int i = 0; i < REGION_SLOTS; i++)
            begin
                base_tab[i]   = '0;
                size_tab[i]   = '0;
                backed_tab[i] = '0;
                offset_tab[i] = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // apply an accepted beat to the table and queue its result
        function void predict_beat(logic op, logic [SLOT_W-1:0] slot,
                                   logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] sz,
                                   logic [ADDR_W-1:0] bk, logic [ADDR_W-1:0] toff,
                                   logic [ADDR_W-1:0] addr);
            xlate_result_t     r;
            logic [ADDR_W-1:0] delta;
            bit                found;
            r.status   = ST_LOADED;
            r.offset   = '0;
            r.hit_slot = '0;
            found      = 1'b0;
            if (op == OP_LOAD)
            begin
                if (slot < REGION_SLOTS)
                begin
                    base_tab[slot]   = base;
                    size_tab[slot]   = sz;
                    backed_tab[slot] = bk;
                    offset_tab[slot] = toff;
                end
            end
            else
            begin
                r.status = ST_MISS;
                // first mapped region in index order that contains the address
                for (int i = 0; i < REGION_SLOTS; i++)
                begin
                    delta = addr - base_tab[i];
                    if (!found && base_tab[i] != 0 && addr >= base_tab[i]
                        && delta < size_tab[i])
                    begin
                        found      = 1'b1;
                        r.hit_slot = SLOT_W'(i);
                        if (delta < backed_tab[i])
                        begin
                            r.status = ST_HIT;
                            r.offset = offset_tab[i] + delta;
                        end
                        else
                            r.status = ST_UNBACKED;
                    end
                end
            end
            owed_results.insert(owed_results.size(), r);
        endfunction

        // compare one result beat against the oldest owed result
        function void compare_result(logic [1:0] st, logic [ADDR_W-1:0] off,
                                     logic [SLOT_W-1:0] hs);
            xlate_result_t w;
            if (owed_results.size() == 0)
            begin
                $error("result beat with nothing pending: status %0d offset %h slot %0d",
                       st, off, hs);
                errors++;
                return;
            end
            w = owed_results.pop_front();
            if (st !== w.status)
            begin
                $error("status: expected %0d, got %0d", w.status, st);
                errors++;
            end
            if (off !== w.offset)
            begin
                $error("translated_offset: expected %h, got %h", w.offset, off);
                errors++;
            end
            if (hs !== w.hit_slot)
            begin
                $error("hit_slot: expected %0d, got %0d", w.hit_slot, hs);
                errors++;
            end
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = OP_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    region_table_mirror    mirror;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_cycles   = 0;
    int                    cycle_count   = 0;

    section_address_translator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            mirror.compare_result(m_tuser, m_tdata[ADDR_W-1:0],
                                  m_tdata[ADDR_W+SLOT_W-1:ADDR_W]);
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // offer one beat, wait for the handshake, return at the next falling edge
    task automatic send_beat(input logic op, input logic [SLOT_W-1:0] slot,
                             input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] sz,
                             input logic [ADDR_W-1:0] bk, input logic [ADDR_W-1:0] toff,
                             input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_DATA_W - SLOT_W - 5 * ADDR_W){1'b0}},
                     addr, toff, bk, sz, base, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        mirror.predict_beat(op, slot, base, sz, bk, toff, addr);
        @(negedge clk);
    endtask

    task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] base,
                             input logic [ADDR_W-1:0] sz, input logic [ADDR_W-1:0] bk,
                             input logic [ADDR_W-1:0] toff);
        send_beat(OP_LOAD, slot, base, sz, bk, toff, rand64());
    endtask

    // load fields are don't-care on a translate, so fill them with noise
    task automatic xlate(input logic [ADDR_W-1:0] addr);
        send_beat(OP_XLATE, SLOT_W'($urandom_range(63)), rand64(), rand64(), rand64(),
                  rand64(), addr);
    endtask

    // stop offering and wait for every owed result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (mirror.pending() > 0)
            @(negedge clk);
    endtask

    // mostly loads of plausible regions and lookups aimed at their edges
    task automatic random_beat();
        int                pick;
        int                idx;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] sz;
        logic [ADDR_W-1:0] bk;
        logic [ADDR_W-1:0] delta;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // noise: unaimed lookup
            xlate(rand64());
        end
        else if (pick < 40)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                base = '0;
            else if (pick < 30)
                base = ADDR_W'($urandom_range(1, 1 << 20));
            else
                base = rand64();
            pick = $urandom_range(99);
            if (pick < 5)
                sz = '0;
            else if (pick < 65)
                sz = ADDR_W'($urandom_range(1, 65536));
            else if (pick < 85)
                sz = {32'h0, $urandom()};
            else if (pick < 95)
                sz = rand64();
            else
                sz = '1;
            case ($urandom_range(5))
                0:       bk = '0;
                1:       bk = sz;
                2:       bk = sz >> 1;
                3:       bk = rand64();
                4:       bk = '1;
                default: bk = sz - ADDR_W'($urandom_range(0, 16));
            endcase
            load_slot(SLOT_W'($urandom_range(63)), base, sz, bk, rand64());
        end
        else
        begin
            // aim at a mapped region when one turns up quickly
            idx = $urandom_range(REGION_SLOTS - 1);
            for (int t = 0; t < 8 && mirror.base_tab[idx] == 0; t++)
                idx = $urandom_range(REGION_SLOTS - 1);
            base = mirror.base_tab[idx];
            sz   = mirror.size_tab[idx];
            bk   = mirror.backed_tab[idx];
            if (base == 0)
                xlate(rand64());
            else
            begin
                case ($urandom_range(9))
                    0:       delta = '0;
                    1:       delta = sz - 1;
                    2:       delta = sz;
                    3:       delta = bk;
                    4:       delta = bk - 1;
                    5:       delta = '1;
                    default: delta = (sz != 0) ? rand64() % sz : '0;
                endcase
                xlate(base + delta);
            end
        end
    endtask

    // main sequence
    initial
    begin
        mirror = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: empty table, edges, overlap, unmapping, wrap, extremes
        xlate('0);
        xlate('1);
        load_slot(6'd0, 64'h1000, 64'h100, 64'h80, 64'h5000);
        xlate(64'h1000);
        xlate(64'h107F);
        xlate(64'h1080);
        xlate(64'h1100);
        xlate(64'h0FFF);
        load_slot(6'd63, '1, '1, '1, '1);
        xlate('1);
        load_slot(6'd5, 64'h2000, 64'h1000, '1, 64'hFFFF_FFFF_FFFF_FFF0);
        xlate(64'h2020);
        load_slot(6'd6, 64'h2000, 64'h10, '0, '0);
        xlate(64'h2008);
        load_slot(6'd5, '0, 64'h1000, '1, '0);
        xlate(64'h2008);
        load_slot(6'd7, 64'h3000, '0, 64'h10, 64'h7000);
        xlate(64'h3000);
        load_slot(6'd1, 64'h1, '1, '1, '0);
        xlate(64'h8000_0000_0000_0000);
        load_slot(6'd1, '0, '0, '0, '0);
        xlate(64'h8000_0000_0000_0000);
        drain_results();

        // sender lightly idle, receiver often stalled
        send_idle_pct = 15;
        recv_idle_pct = 51;
        repeat (125) random_beat();
        drain_results();

        // roles swapped, with a full pause in the middle
        send_idle_pct = 51;
        recv_idle_pct = 15;
        repeat (60) random_beat();
        drain_results();
        repeat (65) random_beat();
        drain_results();

        // no idling, receiver holds off long enough to back up the chain
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        hold_cycles = HOLD_STRETCH;
        @(negedge clk);
        repeat (125) random_beat();
        drain_results();

        // catch any stray beats
        repeat (XLATE_LATENCY + 8) @(negedge clk);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
